FILE: rtl/stpr_pkg.sv
// shared types and constants for the stepper trapezoid ramp block
// no dependencies; imported by every rtl module of the block
package stpr_pkg;

	localparam int POS_W   = 32;               // stored position width
	localparam int CMP_W   = (POS_W > 32) ? POS_W : 32;
	localparam int CNT_W   = 32;               // step count and pulse counter width
	localparam int FREQ_W  = 16;
	localparam int RS_W    = 20;               // ramp_steps width
	localparam int LV_W    = 8;                // ramp_levels width
	localparam int NT_W    = 34;               // signed threshold width
	localparam int RC_W    = 36;               // ramp compare width
	localparam int DIV_W   = 20;               // divider dividend width
	localparam int DCNT_W  = $clog2(DIV_W + 1);
	localparam int CFG_W   = 20;
	localparam int IN_W    = 40;
	localparam int OUT_W   = 88;
	localparam int OPOS_W  = 32;               // width of position fields in a result

	localparam logic [FREQ_W-1:0] MAX_FREQ_RST   = 16'd10000;
	localparam logic [FREQ_W-1:0] MIN_FREQ_RST   = 16'd1000;
	localparam logic [RS_W-1:0]   RAMP_STEPS_RST = 20'd3000;
	localparam logic [LV_W-1:0]   RAMP_LEVELS_RST = 8'd100;
	localparam logic [31:0]       LIMIT_RST      = 32'd10000;
	localparam logic [LV_W-1:0]   LEVELS_SAT     = 8'd255;

	typedef enum logic [1:0] {
		REQ_START = 2'd0,
		REQ_PULSE = 2'd1,
		REQ_HOME  = 2'd2,
		REQ_LIMIT = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		CFG_MAX_FREQ    = 2'd0,
		CFG_MIN_FREQ    = 2'd1,
		CFG_RAMP_STEPS  = 2'd2,
		CFG_RAMP_LEVELS = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_DIV_F,
		ST_DIV_S,
		ST_CLAMP,
		ST_PASS_A,
		ST_PASS_B,
		ST_PASS_C,
		ST_FINISH,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

FILE: rtl/stpr_div.sv
// restoring divider, one quotient bit per cycle, shared by both move-start divisions
// depends on stpr_pkg
module stpr_div import stpr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [LV_W-1:0]  divisor,
	output logic [DIV_W-1:0] quotient,
	output div_stat_t        stat
);

	logic [DIV_W-1:0]  quo_q;
	logic [LV_W-1:0]   rem_q;
	logic [LV_W-1:0]   dvs_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [LV_W:0] rem_sh;
	logic [LV_W:0] rem_nx;
	logic          fits;

	always_comb begin
		rem_sh = {rem_q, quo_q[DIV_W-1]};
		fits   = rem_sh >= {1'b0, dvs_q};
		rem_nx = fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= rem_nx[LV_W-1:0];
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

FILE: rtl/stepper_trapezoid_ramp_top.sv
// stepper trapezoid ramp: request decode, move sequencer, ramp passes and result register
// depends on stpr_pkg and stpr_div
//
// Each request gives exactly one result. A move start runs the two divisions (rate
// increment and steps per level) one after the other on a single bit-serial divider, then
// runs ramp passes, or goes straight to finishing when the move has zero steps. A pulse
// that keeps the move going runs ramp passes too; usually one or two passes are run, but
// with zero steps per level a full climb and fall can take about a thousand passes on one
// request. Every request can wait for a full output register before its result is loaded.
// The input is not ready while a request is being worked on; a finished result waits in
// the output register while the next request is taken.
module stepper_trapezoid_ramp_top import stpr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// step_count[31:0], toward_home[32], unchecked[33], zero fill
	input  logic [IN_W-1:0]  s_tdata,
	// req_type[1:0]
	input  logic [1:0]       s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	// step_freq[15:0], busy_res[16], dir_out[17], move_done[18],
	// position_now[50:19], limit_now[82:51], zero fill
	output logic [OUT_W-1:0] m_tdata,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_addr,
	input  logic [CFG_W-1:0] cfg_wdata
);

	state_t state_q, state_d;

	// configuration
	logic [FREQ_W-1:0] max_freq_q, min_freq_q;
	logic [RS_W-1:0]   ramp_steps_q;
	logic [LV_W-1:0]   ramp_levels_q;

	// captured request
	req_t              req_q;
	logic [CNT_W-1:0]  step_q;
	logic              home_q, unch_q;

	// move state
	logic [POS_W-1:0]         position_q, limit_q;
	logic [CNT_W-1:0]         pulses_q, dest_q;
	logic [FREQ_W-1:0]        freq_q, inc_q;
	logic [RS_W-1:0]          spl_q;
	logic signed [NT_W-1:0]   nt_q;
	logic [LV_W-1:0]          lvl_q;
	logic                     dec_q, moving_q, dir_q, munch_q, done_q;

	// snapshot at the start of a ramp pass
	logic [FREQ_W-1:0]        snap_f_q;
	logic [LV_W-1:0]          snap_y_q;
	logic signed [NT_W-1:0]   snap_n_q;
	logic                     snap_d_q;

	// output register
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;

	// divider
	logic              div_start;
	logic [DIV_W-1:0]  div_dividend;
	logic [DIV_W-1:0]  div_quo;
	div_stat_t         div_stat;

	logic [LV_W-1:0]   eff_lv;
	logic [FREQ_W-1:0] span;

	assign eff_lv = (ramp_levels_q == '0) ? LV_W'(1) : ramp_levels_q;
	assign span   = (max_freq_q > min_freq_q) ? (max_freq_q - min_freq_q) : '0;

	stpr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (eff_lv),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	// ramp arithmetic
	logic signed [LV_W:0]         lv_diff;
	logic signed [RS_W+LV_W+1:0]  prod;
	logic signed [NT_W-1:0]       spl_ext;
	logic signed [RC_W-1:0]       p_s, half_s, nt_s, dec_lhs;
	logic [FREQ_W:0]              fsum, min_plus;
	logic [FREQ_W-1:0]            freq_up, freq_dn;
	logic [CNT_W:0]               pulses_inc;

	always_comb begin
		lv_diff  = $signed({1'b0, eff_lv}) - $signed({1'b0, lvl_q});
		prod     = $signed({1'b0, spl_q}) * lv_diff;
		spl_ext  = $signed({{(NT_W-RS_W){1'b0}}, spl_q});
		p_s      = $signed({{(RC_W-CNT_W){1'b0}}, pulses_q});
		half_s   = $signed({{(RC_W-RS_W+1){1'b0}}, ramp_steps_q[RS_W-1:1]});
		nt_s     = RC_W'(nt_q);
		dec_lhs  = $signed({{(RC_W-CNT_W){1'b0}}, dest_q})
		         - $signed({{(RC_W-RS_W){1'b0}}, ramp_steps_q}) + nt_s;
		fsum     = {1'b0, freq_q} + {1'b0, inc_q};
		freq_up  = fsum[FREQ_W] ? {FREQ_W{1'b1}} : fsum[FREQ_W-1:0];
		min_plus = {1'b0, min_freq_q} + {1'b0, inc_q};
		freq_dn  = ({1'b0, freq_q} >= min_plus) ? (freq_q - inc_q) : min_freq_q;
		pulses_inc = {1'b0, pulses_q} + 1'b1;
	end

	// move clamping
	logic [CMP_W-1:0] pos_c, lim_c, n_c, room_c, dest_c;
	logic [CNT_W-1:0] dest_new;

	always_comb begin
		pos_c  = CMP_W'(position_q);
		lim_c  = CMP_W'(limit_q);
		n_c    = CMP_W'(step_q);
		room_c = lim_c - pos_c;
		if (unch_q)
			dest_c = n_c;
		else if (home_q)
			dest_c = (pos_c < n_c) ? pos_c : n_c;
		else if (lim_c < pos_c)
			dest_c = '0;
		else
			dest_c = (n_c > room_c) ? room_c : n_c;
		dest_new = CNT_W'(dest_c);
	end

	logic pass_same;
	assign pass_same = (snap_f_q == freq_q) && (snap_y_q == lvl_q) &&
	                   (snap_n_q == nt_q) && (snap_d_q == dec_q);

	logic out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		div_start    = 1'b0;
		div_dividend = {{(DIV_W-FREQ_W){1'b0}}, span};
		out_load     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_d = ST_DECODE;
			end
			ST_DECODE: begin
				case (req_q)
					REQ_START: begin
						if (!moving_q) begin
							div_start = 1'b1;
							state_d   = ST_DIV_F;
						end else begin
							state_d = ST_RESULT;
						end
					end
					REQ_PULSE: begin
						if (!moving_q)
							state_d = ST_RESULT;
						else if (pulses_inc >= {1'b0, dest_q})
							state_d = ST_FINISH;
						else
							state_d = ST_PASS_A;
					end
					default: state_d = ST_RESULT;
				endcase
			end
			ST_DIV_F: begin
				if (div_stat.done) begin
					div_start    = 1'b1;
					div_dividend = DIV_W'(ramp_steps_q);
					state_d      = ST_DIV_S;
				end
			end
			ST_DIV_S: begin
				if (div_stat.done)
					state_d = ST_CLAMP;
			end
			ST_CLAMP: begin
				state_d = (dest_new == '0) ? ST_FINISH : ST_PASS_A;
			end
			ST_PASS_A: state_d = ST_PASS_B;
			ST_PASS_B: state_d = ST_PASS_C;
			ST_PASS_C: state_d = pass_same ? ST_RESULT : ST_PASS_A;
			ST_FINISH: state_d = ST_RESULT;
			ST_RESULT: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_freq_q    <= MAX_FREQ_RST;
			min_freq_q    <= MIN_FREQ_RST;
			ramp_steps_q  <= RAMP_STEPS_RST;
			ramp_levels_q <= RAMP_LEVELS_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_addr))
				CFG_MAX_FREQ:    max_freq_q    <= cfg_wdata[FREQ_W-1:0];
				CFG_MIN_FREQ:    min_freq_q    <= cfg_wdata[FREQ_W-1:0];
				CFG_RAMP_STEPS:  ramp_steps_q  <= cfg_wdata[RS_W-1:0];
				CFG_RAMP_LEVELS: ramp_levels_q <= cfg_wdata[LV_W-1:0];
				default: ;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			req_q  <= req_t'(s_tuser);
			step_q <= s_tdata[CNT_W-1:0];
			home_q <= s_tdata[CNT_W];
			unch_q <= s_tdata[CNT_W+1];
		end
	end

	// move datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			limit_q    <= POS_W'(LIMIT_RST);
			pulses_q   <= '0;
			dest_q     <= '0;
			freq_q     <= '0;
			inc_q      <= '0;
			spl_q      <= '0;
			nt_q       <= '0;
			lvl_q      <= '0;
			dec_q      <= 1'b0;
			moving_q   <= 1'b0;
			dir_q      <= 1'b0;
			munch_q    <= 1'b0;
			done_q     <= 1'b0;
			snap_f_q   <= '0;
			snap_y_q   <= '0;
			snap_n_q   <= '0;
			snap_d_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_DECODE: begin
					done_q <= 1'b0;
					case (req_q)
						REQ_PULSE: begin
							if (moving_q)
								pulses_q <= pulses_inc[CNT_W-1:0];
						end
						REQ_HOME: begin
							if (!moving_q)
								position_q <= '0;
						end
						REQ_LIMIT: begin
							if (!moving_q)
								limit_q <= position_q;
						end
						default: ;
					endcase
				end
				ST_DIV_F: begin
					if (div_stat.done)
						inc_q <= div_quo[FREQ_W-1:0];
				end
				ST_DIV_S: begin
					if (div_stat.done)
						spl_q <= div_quo[RS_W-1:0];
				end
				ST_CLAMP: begin
					dest_q   <= dest_new;
					pulses_q <= '0;
					lvl_q    <= '0;
					dec_q    <= 1'b0;
					nt_q     <= spl_ext;
					freq_q   <= min_freq_q;
					dir_q    <= home_q;
					munch_q  <= unch_q;
					moving_q <= 1'b1;
				end
				ST_PASS_A: begin
					snap_f_q <= freq_q;
					snap_y_q <= lvl_q;
					snap_n_q <= nt_q;
					snap_d_q <= dec_q;
					// halfway through the ramp: switch to the falling side
					if (!dec_q && p_s >= half_s) begin
						dec_q <= 1'b1;
						nt_q  <= NT_W'(prod);
					end
				end
				ST_PASS_B: begin
					if (!snap_d_q) begin
						if (p_s >= nt_s) begin
							if (freq_q < max_freq_q) begin
								nt_q   <= nt_q + spl_ext;
								freq_q <= freq_up;
								if (lvl_q < LEVELS_SAT)
									lvl_q <= lvl_q + 1'b1;
							end else begin
								dec_q <= 1'b1;
								nt_q  <= spl_ext;
							end
						end
					end else if (p_s >= dec_lhs && freq_q > min_freq_q) begin
						nt_q   <= nt_q + spl_ext;
						freq_q <= freq_dn;
					end
				end
				ST_FINISH: begin
					if (!munch_q) begin
						if (dir_q)
							position_q <= position_q - POS_W'(dest_q);
						else
							position_q <= position_q + POS_W'(dest_q);
					end
					moving_q <= 1'b0;
					freq_q   <= '0;
					done_q   <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {
				{(OUT_W-83){1'b0}},
				OPOS_W'(limit_q),
				OPOS_W'(position_q),
				done_q,
				dir_q,
				moving_q,
				moving_q ? freq_q : {FREQ_W{1'b0}}
			};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

FILE: rtl/stpr_checker.sv
// port-level checks for the stepper trapezoid ramp top, attached by bind
// depends on stpr_pkg
module stpr_checker import stpr_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// no rate reported when no move runs
	a_idle_freq: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[16] |-> m_tdata[15:0] == 16'd0)
		else $error("nonzero rate while stopped");

	// a completing request leaves the block stopped
	a_done_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[18] |-> !m_tdata[16])
		else $error("move done while still busy");

	// one request at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("new request taken while busy");

endmodule

bind stepper_trapezoid_ramp_top stpr_checker u_stpr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: dv/tb.sv
// self-checking testbench for stepper_trapezoid_ramp_top: stream driver and monitor,
// a behavioral copy of the ramp profile that predicts each status, and a request generator
// depends on rtl/stpr_pkg.sv and rtl/stepper_trapezoid_ramp_top.sv
`timescale 1ns / 100ps

module tb;
	import stpr_pkg::*;

	localparam int QUIET_LIMIT = 20000;  // cycles with no transfer on either side
	localparam int TAIL_CYCLES = 1000;
	localparam int PHASE_ITEMS = 140;
	localparam int N_PHASES    = 10;
	localparam int SHOW_MAX    = 10;

	typedef struct packed {
		req_t        kind;
		logic [31:0] count;
		logic        home;
		logic        unch;
	} motor_req_t;

	typedef struct packed {
		logic [15:0] freq;
		logic        busy;
		logic        dir;
		logic        done;
		logic [31:0] pos;
		logic [31:0] lim;
	} motor_status_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_LIGHT,
		RX_HEAVY,
		RX_PERIODIC
	} rx_mode_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic [1:0]       s_tuser = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic             cfg_we = 1'b0;
	logic [1:0]       cfg_addr = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	stepper_trapezoid_ramp_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	// predictor copy of the configuration and the motion state
	logic [15:0] reg_max_freq = MAX_FREQ_RST;
	logic [15:0] reg_min_freq = MIN_FREQ_RST;
	logic [19:0] reg_ramp_steps = RAMP_STEPS_RST;
	logic [7:0]  reg_ramp_levels = RAMP_LEVELS_RST;

	logic [31:0] mot_pos = '0;
	logic [31:0] mot_lim = LIMIT_RST;
	logic [31:0] mot_dest = '0;
	logic [31:0] mot_pulses = '0;
	logic [15:0] mot_freq = '0;
	logic [15:0] mot_inc = '0;
	logic [19:0] mot_spl = '0;
	longint      mot_thr = 0;
	logic [7:0]  mot_climbed = '0;
	logic        mot_decel = 1'b0;
	logic        mot_moving = 1'b0;
	logic        mot_dir = 1'b0;
	logic        mot_unch = 1'b0;

	// generator view of where the motor will be, used to size pulse trains
	int unsigned plan_pos = 0;
	int unsigned plan_lim = LIMIT_RST;

	motor_req_t    pending_req[$];
	motor_status_t expected_status[$];
	motor_req_t    drv_req;

	int burst_left = 0;
	int gap_left = 0;
	int quiet_cycles = 0;
	int rx_cycle = 0;
	rx_mode_t rx_mode = RX_OPEN;

	int n_mismatch = 0;
	int n_checked = 0;
	int n_accepted = 0;
	int n_moves = 0;
	int n_profiles = 0;

	function automatic int unsigned levels_eff();
		return (reg_ramp_levels == 8'd0) ? 1 : int'(reg_ramp_levels);
	endfunction

	// one evaluation of the accelerate / decelerate rules
	function automatic void rate_pass();
		longint p;
		longint spl;
		int unsigned f;
		int unsigned half;
		p = longint'(mot_pulses);
		spl = longint'(mot_spl);
		half = int'(reg_ramp_steps) >> 1;
		if (!mot_decel) begin
			if (p >= longint'(half)) begin
				mot_decel = 1'b1;
				mot_thr = spl * (longint'(levels_eff()) - longint'(mot_climbed));
			end
			if (p >= mot_thr) begin
				if (mot_freq < reg_max_freq) begin
					f = int'(mot_freq) + int'(mot_inc);
					mot_thr += spl;
					mot_freq = (f > 65535) ? 16'hFFFF : f[15:0];
					if (mot_climbed < LEVELS_SAT)
						mot_climbed++;
				end else begin
					mot_decel = 1'b1;
					mot_thr = spl;
				end
			end
		end else begin
			if (p >= longint'(mot_dest) - longint'(reg_ramp_steps) + mot_thr) begin
				if (mot_freq > reg_min_freq) begin
					mot_thr += spl;
					if (int'(mot_freq) >= int'(reg_min_freq) + int'(mot_inc))
						mot_freq -= mot_inc;
					else
						mot_freq = reg_min_freq;
				end
			end
		end
	endfunction

	// apply every update due at the present count
	function automatic void rate_settle();
		logic [15:0] f0;
		logic [7:0]  y0;
		longint      t0;
		logic        d0;
		forever begin
			f0 = mot_freq;
			y0 = mot_climbed;
			t0 = mot_thr;
			d0 = mot_decel;
			rate_pass();
			if (f0 == mot_freq && y0 == mot_climbed && t0 == mot_thr && d0 == mot_decel)
				break;
		end
	endfunction

	function automatic void move_finish();
		if (!mot_unch)
			mot_pos = mot_dir ? mot_pos - mot_dest : mot_pos + mot_dest;
		mot_moving = 1'b0;
		mot_freq = '0;
	endfunction

	function automatic motor_status_t status_after(motor_req_t r);
		motor_status_t st;
		logic done;
		int unsigned lv;
		done = 1'b0;
		case (r.kind)
			REQ_START: begin
				if (!mot_moving) begin
					lv = levels_eff();
					mot_inc = (reg_max_freq > reg_min_freq) ?
						16'((int'(reg_max_freq) - int'(reg_min_freq)) / lv) : 16'd0;
					mot_spl = 20'(int'(reg_ramp_steps) / lv);
					if (r.unch)
						mot_dest = r.count;
					else if (r.home)
						mot_dest = (mot_pos < r.count) ? mot_pos : r.count;
					else if (mot_lim < mot_pos)
						mot_dest = '0;
					else
						mot_dest = (r.count > mot_lim - mot_pos) ? mot_lim - mot_pos : r.count;
					mot_pulses = '0;
					mot_climbed = '0;
					mot_decel = 1'b0;
					mot_thr = longint'(mot_spl);
					mot_freq = reg_min_freq;
					mot_dir = r.home;
					mot_unch = r.unch;
					mot_moving = 1'b1;
					if (mot_dest == '0) begin
						move_finish();
						done = 1'b1;
					end else begin
						rate_settle();
					end
				end
			end
			REQ_PULSE: begin
				if (mot_moving) begin
					mot_pulses++;
					if (mot_pulses >= mot_dest) begin
						move_finish();
						done = 1'b1;
					end else begin
						rate_settle();
					end
				end
			end
			REQ_HOME: begin
				if (!mot_moving)
					mot_pos = '0;
			end
			default: begin
				if (!mot_moving)
					mot_lim = mot_pos;
			end
		endcase
		st.freq = mot_moving ? mot_freq : 16'd0;
		st.busy = mot_moving;
		st.dir  = mot_dir;
		st.done = done;
		st.pos  = mot_pos;
		st.lim  = mot_lim;
		return st;
	endfunction

	// driver: bursts of requests separated by random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_status.push_back(status_after(drv_req));
				n_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_req.size() > 0) begin
					drv_req = pending_req.pop_front();
					s_tdata <= {{(IN_W-34){1'b0}}, drv_req.unch, drv_req.home, drv_req.count};
					s_tuser <= drv_req.kind;
					s_tvalid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each status against the oldest prediction, stall on its own pattern
	always @(posedge clk) begin
		motor_status_t got;
		motor_status_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.freq = m_tdata[15:0];
				got.busy = m_tdata[16];
				got.dir  = m_tdata[17];
				got.done = m_tdata[18];
				got.pos  = m_tdata[50:19];
				got.lim  = m_tdata[82:51];
				n_checked++;
				if (expected_status.size() == 0) begin
					n_mismatch++;
					if (n_mismatch <= SHOW_MAX)
						$display("unexpected status freq=%0d busy=%0b dir=%0b done=%0b pos=%0d lim=%0d",
							got.freq, got.busy, got.dir, got.done, got.pos, got.lim);
				end else begin
					want = expected_status.pop_front();
					if (want.done)
						n_moves++;
					if (got.freq !== want.freq || got.busy !== want.busy || got.dir !== want.dir ||
					    got.done !== want.done || got.pos !== want.pos || got.lim !== want.lim) begin
						n_mismatch++;
						if (n_mismatch <= SHOW_MAX) begin
							$display("status %0d: exp freq=%0d busy=%0b dir=%0b done=%0b pos=%0d lim=%0d",
								n_checked, want.freq, want.busy, want.dir, want.done, want.pos, want.lim);
							$display("status %0d: got freq=%0d busy=%0b dir=%0b done=%0b pos=%0d lim=%0d",
								n_checked, got.freq, got.busy, got.dir, got.done, got.pos, got.lim);
						end
					end
				end
			end
			rx_cycle++;
			if (rx_cycle % 256 == 0)
				rx_mode = rx_mode_t'($urandom_range(0, 3));
			case (rx_mode)
				RX_OPEN:  m_tready <= 1'b1;
				RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
				RX_HEAVY: m_tready <= ($urandom_range(0, 3) == 0);
				default:  m_tready <= (rx_cycle % 8 == 5);
			endcase
		end
	end

	// watchdog on transfers
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("no transfer for %0d cycles, %0d statuses still due",
					QUIET_LIMIT, expected_status.size());
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic write_reg(cfg_idx_t idx, int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= CFG_W'(val);
		case (idx)
			CFG_MAX_FREQ:   reg_max_freq = 16'(val);
			CFG_MIN_FREQ:   reg_min_freq = 16'(val);
			CFG_RAMP_STEPS: reg_ramp_steps = 20'(val);
			default:        reg_ramp_levels = 8'(val);
		endcase
	endtask

	task automatic set_profile(int unsigned fmax, int unsigned fmin, int unsigned steps,
	                           int unsigned levels);
		write_reg(CFG_MAX_FREQ, fmax);
		write_reg(CFG_MIN_FREQ, fmin);
		write_reg(CFG_RAMP_STEPS, steps);
		write_reg(CFG_RAMP_LEVELS, levels);
		@(posedge clk);
		cfg_we <= 1'b0;
		n_profiles++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_req.size() != 0 || s_tvalid || expected_status.size() != 0);
	endtask

	task automatic push_item(req_t kind, logic [31:0] count, logic home, logic unch);
		motor_req_t r;
		r.kind = kind;
		r.count = count;
		r.home = home;
		r.unch = unch;
		pending_req.push_back(r);
	endtask

	task automatic push_busy_noise(req_t kind);
		push_item(kind, $urandom(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	// start request plus exactly the pulses it needs; noise_mode 1 sprinkles ignored
	// requests into the move, 2 puts one of each kind before the first pulse
	task automatic push_move(logic [31:0] n, logic home, logic unch, int noise_mode);
		int unsigned dest;
		int unsigned k;
		if (unch)
			dest = n;
		else if (home)
			dest = (plan_pos < n) ? plan_pos : n;
		else if (plan_lim < plan_pos)
			dest = 0;
		else
			dest = (n > plan_lim - plan_pos) ? plan_lim - plan_pos : n;
		push_item(REQ_START, n, home, unch);
		for (int unsigned i = 0; i < dest; i++) begin
			if (noise_mode == 2 && i == 0) begin
				push_busy_noise(REQ_START);
				push_busy_noise(REQ_HOME);
				push_busy_noise(REQ_LIMIT);
			end else if (noise_mode == 1 && $urandom_range(0, 11) == 0) begin
				k = $urandom_range(0, 2);
				push_busy_noise(k == 0 ? REQ_START : (k == 1 ? REQ_HOME : REQ_LIMIT));
			end
			push_busy_noise(REQ_PULSE);
		end
		if (!unch)
			plan_pos = home ? plan_pos - dest : plan_pos + dest;
	endtask

	task automatic fill_phase(int target);
		int unsigned k;
		logic home;
		logic unch;
		logic [31:0] n;
		while (pending_req.size() < target) begin
			k = $urandom_range(0, 19);
			if (plan_lim == LIMIT_RST && plan_pos >= 30) begin
				push_busy_noise(REQ_LIMIT);
				plan_lim = plan_pos;
			end else if (k == 0) begin
				push_busy_noise(REQ_PULSE);
			end else if (k == 1) begin
				push_busy_noise(REQ_HOME);
				plan_pos = 0;
			end else if (k == 2 && plan_pos >= 30) begin
				push_busy_noise(REQ_LIMIT);
				plan_lim = plan_pos;
			end else begin
				home = 1'($urandom_range(0, 1));
				unch = ($urandom_range(0, 5) == 0);
				// full-width counts only where clamping keeps the move short
				if (!unch && home && plan_pos <= 40 && $urandom_range(0, 1) == 0)
					n = $urandom();
				else if (!unch && !home && plan_lim - plan_pos <= 40 && $urandom_range(0, 1) == 0)
					n = $urandom();
				else if ($urandom_range(0, 3) == 0)
					n = $urandom_range(0, 4);
				else
					n = $urandom_range(0, 40);
				push_move(n, home, unch, 1);
			end
		end
	endtask

	initial begin
		int unsigned fmax;
		int unsigned fmin;
		int unsigned steps;
		int unsigned levels;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: zero-length moves, clamping at home, ignored requests
		set_profile(5000, 1000, 8, 3);
		push_item(REQ_PULSE, 32'hFFFF_FFFF, 1'b1, 1'b1);
		push_move(32'd0, 1'b0, 1'b0, 0);
		push_move(32'hFFFF_FFFF, 1'b1, 1'b0, 0);
		push_move(32'd6, 1'b0, 1'b0, 2);
		push_item(REQ_PULSE, 32'd0, 1'b0, 1'b0);
		push_move(32'hFFFF_FFFF, 1'b1, 1'b0, 0);
		push_move(32'd2, 1'b0, 1'b1, 0);
		push_item(REQ_HOME, 32'd0, 1'b0, 1'b0);
		plan_pos = 0;
		wait_drained();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				// climb saturates at the top rate, every level at once
				0: set_profile(65535, 1, 200, 255);
				// inverted span, zero levels, no ramp
				1: set_profile(1, 65535, 0, 0);
				2: set_profile(65535, 65535, 20'hFFFFF, 1);
				3: set_profile(1, 1, 1, 2);
				default: begin
					fmax = $urandom_range(1, 65535);
					fmin = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535) :
						$urandom_range(1, fmax);
					steps = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 20'hFFFFF) :
						$urandom_range(0, 90);
					levels = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) :
						$urandom_range(1, 12);
					set_profile(fmax, fmin, steps, levels);
				end
			endcase
			fill_phase(PHASE_ITEMS);
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("checked %0d status results for %0d requests over %0d ramp profiles",
			n_checked, n_accepted, n_profiles);
		$display("%0d moves completed, %0d mismatching results", n_moves, n_mismatch);
		if (n_mismatch == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: files.f
rtl/stpr_pkg.sv
rtl/stpr_div.sv
rtl/stepper_trapezoid_ramp_top.sv
rtl/stpr_checker.sv
dv/tb.sv
